[design/uhe_pkg.sv]
`default_nettype none

package uhe_pkg;

    localparam int LINE_MAX   = 16;
    localparam int INFO_BYTES = 8;
    localparam int MAX_RESULTS = 8;

    localparam int LINE_CNT_W = $clog2(LINE_MAX + 1);
    localparam int INFO_CNT_W = $clog2(INFO_BYTES + 1);
    localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam int KW_READY_LEN = 5;
    localparam int KW_INFO_LEN  = 4;

    // input commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    // transmit strings, first character in the lowest byte
    localparam logic [39:0] TX_BAD   = {8'h0a, 8'h0d, 8'h64, 8'h61, 8'h62};
    localparam logic [47:0] TX_BFSZ  = {8'h0a, 8'h0d, 8'h7a, 8'h73, 8'h66, 8'h62};
    localparam logic [55:0] TX_READY = {8'h0a, 8'h0d, 8'h79, 8'h64, 8'h61, 8'h65, 8'h72};

    localparam logic [RES_CNT_W-1:0] LEN_BAD   = RES_CNT_W'(5);
    localparam logic [RES_CNT_W-1:0] LEN_BFSZ  = RES_CNT_W'(8);
    localparam logic [RES_CNT_W-1:0] LEN_READY = RES_CNT_W'(7);

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_READY   = 5'b00010,
        PH_INFO    = 5'b00100,
        PH_BYTES   = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // one item's worth of results, handed from the core to the emitter
    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        logic                 pay_first;
        logic                 rep_last;
        logic [63:0]          bytes;
        logic [63:0]          report;
    } t_burst;

    // keyword characters: "ready" or "info"
    function automatic logic [7:0] kw_char(input logic sel_info, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (sel_info) begin
            case (idx)
                3'd0: ch = 8'h69;
                3'd1: ch = 8'h6e;
                3'd2: ch = 8'h66;
                3'd3: ch = 8'h6f;
                default: ch = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0: ch = 8'h72;
                3'd1: ch = 8'h65;
                3'd2: ch = 8'h61;
                3'd3: ch = 8'h64;
                3'd4: ch = 8'h79;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

[design/uhe_core.sv]
`default_nettype none

module uhe_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  logic [1:0]        i_item_cmd,
    input  logic [7:0]        i_item_byte,
    input  logic              i_item_ovr,
    input  logic [15:0]       i_buffer_size,
    input  logic [15:0]       i_timeout_ticks,
    input  logic              i_burst_ready,
    output logic              o_burst_valid,
    output uhe_pkg::t_burst   o_burst
);
    import uhe_pkg::*;

    // input register
    logic        r_item_valid;
    logic [1:0]  r_cmd;
    logic [7:0]  r_byte;
    logic        r_ovr;

    // session state
    t_phase                 r_phase,      n_phase;
    logic [LINE_CNT_W-1:0]  r_line_count, n_line_count;
    logic                   r_prev_cr,    n_prev_cr;
    logic                   r_match_rdy,  n_match_rdy;
    logic                   r_match_info, n_match_info;
    logic [15:0]            r_elapsed,    n_elapsed;
    logic [63:0]            r_shift,      n_shift;
    logic [INFO_CNT_W-1:0]  r_info_count, n_info_count;
    logic [15:0]            r_pay_left,   n_pay_left;

    logic                   w_consume;
    logic [LINE_CNT_W-1:0]  w_pos;
    logic [LINE_CNT_W-1:0]  w_cnt;
    logic                   w_done;
    logic                   w_long;
    logic                   w_mr;
    logic                   w_mi;
    logic [63:0]            w_shift_in;
    logic [INFO_CNT_W-1:0]  w_icnt;
    logic [15:0]            w_pay_dec;
    t_burst                 w_burst;

    assign w_consume    = r_item_valid && i_burst_ready;
    assign o_item_ready = !r_item_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_item_valid && o_item_ready) begin
            r_item_valid <= 1'b1;
        end else if (w_consume) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid && o_item_ready) begin
            r_cmd  <= i_item_cmd;
            r_byte <= i_item_byte;
            r_ovr  <= i_item_ovr;
        end
    end

    // line tracking: keyword prefix flags instead of a stored line
    always_comb begin
        w_pos = (r_line_count >= LINE_CNT_W'(LINE_MAX)) ? '0 : r_line_count;
        w_cnt = w_pos + LINE_CNT_W'(1);
        w_done = (w_cnt >= LINE_CNT_W'(2)) && r_prev_cr && (r_byte == CHAR_LF);
        w_long = !w_done && (w_cnt >= LINE_CNT_W'(LINE_MAX));
        w_mr = (w_pos == '0) ? 1'b1 : r_match_rdy;
        if (w_pos < LINE_CNT_W'(KW_READY_LEN)) begin
            w_mr = w_mr && (r_byte == kw_char(1'b0, w_pos[2:0]));
        end
        w_mi = (w_pos == '0) ? 1'b1 : r_match_info;
        if (w_pos < LINE_CNT_W'(KW_INFO_LEN)) begin
            w_mi = w_mi && (r_byte == kw_char(1'b1, w_pos[2:0]));
        end
        w_shift_in = {r_shift[55:0], r_byte};
        w_icnt     = r_info_count + INFO_CNT_W'(1);
        w_pay_dec  = (r_pay_left != '0) ? r_pay_left - 16'd1 : r_pay_left;
    end

    always_comb begin
        n_phase      = r_phase;
        n_line_count = r_line_count;
        n_prev_cr    = r_prev_cr;
        n_match_rdy  = r_match_rdy;
        n_match_info = r_match_info;
        n_elapsed    = r_elapsed;
        n_shift      = r_shift;
        n_info_count = r_info_count;
        n_pay_left   = r_pay_left;
        w_burst      = '0;

        case (r_cmd)
            CMD_START: begin
                n_phase      = PH_READY;
                n_line_count = '0;
                n_elapsed    = '0;
                n_shift      = '0;
                n_info_count = '0;
                n_pay_left   = '0;
            end
            CMD_TICK: begin
                if ((r_phase == PH_INFO || r_phase == PH_BYTES) && i_timeout_ticks != '0) begin
                    if (r_elapsed >= i_timeout_ticks) begin
                        n_phase      = PH_IDLE;
                        n_line_count = '0;
                    end else begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
            end
            CMD_BYTE: begin
                case (r_phase)
                    PH_READY: begin
                        if (r_ovr) begin
                            n_line_count  = '0;
                            w_burst.count = LEN_BAD;
                            w_burst.bytes = {24'd0, TX_BAD};
                        end else begin
                            n_prev_cr    = (r_byte == CHAR_CR);
                            n_match_rdy  = w_mr;
                            n_match_info = w_mi;
                            n_line_count = w_cnt;
                            if (w_done && w_mr && w_cnt == LINE_CNT_W'(KW_READY_LEN + 2)) begin
                                n_line_count  = '0;
                                n_phase       = PH_INFO;
                                n_elapsed     = '0;
                                w_burst.count = LEN_BFSZ;
                                w_burst.bytes = {i_buffer_size[7:0], i_buffer_size[15:8],
                                                 TX_BFSZ};
                            end else if (w_done || w_long) begin
                                n_line_count  = '0;
                                w_burst.count = LEN_BAD;
                                w_burst.bytes = {24'd0, TX_BAD};
                            end
                        end
                    end
                    PH_INFO: begin
                        if (r_ovr) begin
                            n_phase      = PH_IDLE;
                            n_line_count = '0;
                        end else begin
                            n_prev_cr    = (r_byte == CHAR_CR);
                            n_match_rdy  = w_mr;
                            n_match_info = w_mi;
                            n_line_count = w_cnt;
                            if (w_done && w_mi && w_cnt == LINE_CNT_W'(KW_INFO_LEN + 2)) begin
                                n_line_count = '0;
                                n_phase      = PH_BYTES;
                                n_shift      = '0;
                                n_info_count = '0;
                                n_elapsed    = '0;
                            end else if (w_done || w_long) begin
                                n_phase      = PH_IDLE;
                                n_line_count = '0;
                            end
                        end
                    end
                    PH_BYTES: begin
                        n_shift      = w_shift_in;
                        n_info_count = w_icnt;
                        if (w_icnt >= INFO_CNT_W'(INFO_BYTES)) begin
                            n_info_count   = '0;
                            n_pay_left     = w_shift_in[15:0];
                            w_burst.bytes  = {8'd0, TX_READY};
                            w_burst.report = w_shift_in;
                            if (w_shift_in[15:0] == '0) begin
                                // empty payload: report right after the ready text
                                w_burst.count    = LEN_READY + RES_CNT_W'(1);
                                w_burst.rep_last = 1'b1;
                                n_phase          = PH_IDLE;
                                n_line_count     = '0;
                            end else begin
                                w_burst.count = LEN_READY;
                                n_phase       = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_pay_left        = w_pay_dec;
                        w_burst.pay_first = 1'b1;
                        w_burst.bytes     = {56'd0, r_byte};
                        w_burst.report    = r_shift;
                        w_burst.count     = RES_CNT_W'(1);
                        if (w_pay_dec == '0) begin
                            w_burst.count    = RES_CNT_W'(2);
                            w_burst.rep_last = 1'b1;
                            n_phase          = PH_IDLE;
                            n_line_count     = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_line_count <= '0;
            r_prev_cr    <= 1'b0;
            r_match_rdy  <= 1'b0;
            r_match_info <= 1'b0;
            r_elapsed    <= '0;
            r_shift      <= '0;
            r_info_count <= '0;
            r_pay_left   <= '0;
        end else if (w_consume) begin
            r_phase      <= n_phase;
            r_line_count <= n_line_count;
            r_prev_cr    <= n_prev_cr;
            r_match_rdy  <= n_match_rdy;
            r_match_info <= n_match_info;
            r_elapsed    <= n_elapsed;
            r_shift      <= n_shift;
            r_info_count <= n_info_count;
            r_pay_left   <= n_pay_left;
        end
    end

    assign o_burst_valid = w_consume;
    assign o_burst       = w_burst;

endmodule

`default_nettype wire

[design/uhe_emit.sv]
`default_nettype none

module uhe_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_burst_valid,
    input  uhe_pkg::t_burst   i_burst,
    output logic              o_burst_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [71:0]       o_data,
    output logic [1:0]        o_kind,
    output logic              o_last
);
    import uhe_pkg::*;

    logic                  r_busy;
    logic [RES_CNT_W-1:0]  r_left;
    logic                  r_first;
    logic                  r_rep;
    logic [63:0]           r_bytes;
    logic [63:0]           r_report;

    logic                  r_valid;
    logic [71:0]           r_data;
    logic [1:0]            r_kind;
    logic                  r_last;

    logic                  w_advance;
    logic                  w_final;
    logic                  w_load;
    logic [1:0]            w_kind;
    logic [71:0]           w_data;

    assign w_advance     = r_busy && (!r_valid || i_ready);
    assign w_final       = (r_left == RES_CNT_W'(1));
    assign o_burst_ready = !r_busy || (w_advance && w_final);
    assign w_load        = i_burst_valid && (i_burst.count != '0);

    always_comb begin
        if (r_rep && w_final) begin
            w_kind = KIND_REPORT;
        end else if (r_first) begin
            w_kind = KIND_PAYLOAD;
        end else begin
            w_kind = KIND_TX;
        end
        if (w_kind == KIND_REPORT) begin
            w_data = {r_report[15:0], r_report[23:16], r_report[31:24],
                      r_report[63:32], 8'd0};
        end else begin
            w_data = {64'd0, r_bytes[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_busy <= 1'b1;
        end else if (w_advance && w_final) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_left   <= i_burst.count;
            r_first  <= i_burst.pay_first;
            r_rep    <= i_burst.rep_last;
            r_bytes  <= i_burst.bytes;
            r_report <= i_burst.report;
        end else if (w_advance) begin
            r_left  <= r_left - RES_CNT_W'(1);
            r_first <= 1'b0;
            r_bytes <= {8'd0, r_bytes[63:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_data <= w_data;
            r_kind <= w_kind;
            r_last <= w_final;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[design/uart_host_handshake_engine.sv]
// channel   dir   handshake                       payload
// s_axis    in    s_axis_tvalid / s_axis_tready   tdata: rx_byte; tuser: command, overrun
// m_axis    out   m_axis_tvalid / m_axis_tready   tdata: result fields; tuser: kind; tlast
// apb       in    psel, penable, pwrite, pready   0x0 buffer_size, 0x4 timeout_ticks
//
// an item waits in the input register until the emitter can take it, and its whole state
// update is done as it is handed over; its results (up to eight) leave the emitter one per
// cycle while the output is ready, and an item holds the emitter until its last result has
// gone into the single output register; items with one result or none stream at that rate.
// synchronous active-low reset; no clearing pass, the block is ready right after reset.
// a stalled output holds the emitter, which in turn holds the input register.
`default_nettype none

module uart_host_handshake_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_axis_tuser,   // [1:0] command, [2] overrun
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] byte_value, [39:8] sample_rate, [47:40] bit_depth, [55:48] channels,
    // [71:56] data_length
    output logic [71:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uhe_pkg::*;

    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    logic [15:0] r_buffer_size;
    logic [15:0] r_timeout_ticks;
    logic        w_cfg_wr;

    logic        w_burst_valid;
    logic        w_burst_ready;
    t_burst      w_burst;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // word-aligned registers, low address bits ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size   <= 16'd4096;
            r_timeout_ticks <= 16'd2000;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_BUFFER_SIZE) begin
                r_buffer_size <= pwdata[15:0];
            end else begin
                r_timeout_ticks <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout_ticks}
                                              : {16'd0, r_buffer_size};

    uhe_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (s_axis_tvalid),
        .o_item_ready    (s_axis_tready),
        .i_item_cmd      (s_axis_tuser[1:0]),
        .i_item_byte     (s_axis_tdata),
        .i_item_ovr      (s_axis_tuser[2]),
        .i_buffer_size   (r_buffer_size),
        .i_timeout_ticks (r_timeout_ticks),
        .i_burst_ready   (w_burst_ready),
        .o_burst_valid   (w_burst_valid),
        .o_burst         (w_burst)
    );

    uhe_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (w_burst_valid),
        .i_burst       (w_burst),
        .o_burst_ready (w_burst_ready),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_kind        (m_axis_tuser),
        .o_last        (m_axis_tlast)
    );

`ifndef SYNTH
    // a report always closes the results of its item
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_REPORT |-> m_axis_tlast)
        else $error("report transfer without tlast");

    // a report follows either one payload byte or the ready text
    a_report_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_burst_valid && w_burst.rep_last |->
            w_burst.count == RES_CNT_W'(2) || w_burst.count == LEN_READY + RES_CNT_W'(1))
        else $error("report burst with unexpected length");

    // a payload byte stands alone or ahead of the report
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_burst_valid && w_burst.pay_first |->
            w_burst.count == RES_CNT_W'(1) || w_burst.count == RES_CNT_W'(2))
        else $error("payload burst with unexpected length");

    // the core hands over an item only when the emitter can take it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_burst_valid |-> w_burst_ready && w_burst.count <= RES_CNT_W'(MAX_RESULTS))
        else $error("burst handed over while emitter is busy");
`endif

endmodule

`default_nettype wire

[verif/uart_host_handshake_engine_test.sv]
`timescale 1ns / 1ps

module uart_host_handshake_engine_test;
    import uhe_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [2:0] ADDR_BUFSZ   = 3'h0;
    localparam logic [2:0] ADDR_TIMEOUT = 3'h4;
    localparam int IDLE_PCT     = 37;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 45;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {LN_WAIT, LN_DONE, LN_LONG} t_line_res;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       ovr;
    } t_stim;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] rate;
        logic [7:0]  depth;
        logic [7:0]  chans;
        logic [15:0] len;
        logic        last;
    } t_reply;

    // typed rows carry transmit bytes only, first byte in the lowest bits
    typedef struct packed {
        t_stim       it;
        logic        typed;
        logic [3:0]  n;
        logic [63:0] text;
    } t_dir;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic [2:0]  s_axis_tuser = 3'd0;   // [1:0] command, [2] overrun
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] byte_value, [39:8] sample_rate, [47:40] bit_depth, [55:48] channels,
    // [71:56] data_length
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;          // [1:0] kind
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    uart_host_handshake_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // session model state
    t_phase      m_phase = PH_IDLE;
    logic [7:0]  m_line [LINE_MAX];
    int          m_line_cnt = 0;
    logic [15:0] m_elapsed = 16'd0;
    logic [63:0] m_info = 64'd0;
    int          m_info_cnt = 0;
    logic [15:0] m_left = 16'd0;
    logic [15:0] m_bufsz = 16'd4096;
    logic [15:0] m_timeout = 16'd2000;

    t_reply step_replies [$];
    t_reply expected_replies [$];
    t_stim  pending_items [$];

    int   error_count = 0;
    int   cycle_count = 0;
    logic no_idle = 1'b0;
    logic pressure_start = 1'b0;
    logic hold_on = 1'b0;

    t_dir directed_rows [29] = '{
        '{'{CMD_BYTE,   8'hff, 1'b0}, 1'b1, 4'd0, 64'd0},   // byte while idle
        '{'{CMD_TICK,   8'h00, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_UNUSED, 8'hff, 1'b1}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_START,  8'h00, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'hff, 1'b1}, 1'b1, 4'd5, {24'd0, TX_BAD}},
        '{'{CMD_BYTE,   CHAR_CR, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   CHAR_LF, 1'b0}, 1'b1, 4'd5, {24'd0, TX_BAD}},   // empty line
        '{'{CMD_BYTE,   "r", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "e", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "a", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "d", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "y", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   CHAR_CR, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   CHAR_LF, 1'b0}, 1'b1, 4'd8, {8'h00, 8'h10, TX_BFSZ}},
        '{'{CMD_TICK,   8'h00, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "i", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "n", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "f", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   "o", 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   CHAR_CR, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   CHAR_LF, 1'b0}, 1'b1, 4'd0, 64'd0},
        // info bytes: rate all ones, depth 0, channels all ones, zero length
        '{'{CMD_BYTE,   8'hff, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'hff, 1'b1}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'hff, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'hff, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'h00, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'hff, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'h00, 1'b0}, 1'b1, 4'd0, 64'd0},
        '{'{CMD_BYTE,   8'h00, 1'b0}, 1'b0, 4'd0, 64'd0}
    };

    function automatic void add_reply(logic [1:0] kind, logic [7:0] value, bit report);
        t_reply r;
        r.kind       = kind;
        r.byte_value = value;
        r.rate       = report ? m_info[63:32] : 32'd0;
        r.depth      = report ? m_info[31:24] : 8'd0;
        r.chans      = report ? m_info[23:16] : 8'd0;
        r.len        = report ? m_info[15:0] : 16'd0;
        r.last       = 1'b0;
        step_replies.push_back(r);
    endfunction

    function automatic void add_text(logic [63:0] s, int n);
        for (int i = 0; i < n; i++) add_reply(KIND_TX, s[8*i +: 8], 1'b0);
    endfunction

    function automatic t_line_res feed_line(logic [7:0] b);
        if (m_line_cnt >= LINE_MAX) m_line_cnt = 0;
        m_line[m_line_cnt] = b;
        m_line_cnt++;
        if (m_line_cnt >= 2 && m_line[m_line_cnt-2] == CHAR_CR &&
            m_line[m_line_cnt-1] == CHAR_LF) return LN_DONE;
        if (m_line_cnt >= LINE_MAX) return LN_LONG;
        return LN_WAIT;
    endfunction

    function automatic bit line_is(string kw);
        if (m_line_cnt != kw.len() + 2) return 1'b0;
        for (int i = 0; i < kw.len(); i++) begin
            if (m_line[i] != kw[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void end_session();
        m_phase    = PH_IDLE;
        m_line_cnt = 0;
    endfunction

    // replies caused by one accepted item, left in step_replies
    function automatic void handshake_step(t_stim it);
        t_line_res lr;
        step_replies.delete();
        case (it.cmd)
            CMD_START: begin
                m_phase    = PH_READY;
                m_line_cnt = 0;
                m_elapsed  = 16'd0;
                m_info     = 64'd0;
                m_info_cnt = 0;
                m_left     = 16'd0;
            end
            CMD_TICK: begin
                if ((m_phase == PH_INFO || m_phase == PH_BYTES) && m_timeout != 16'd0) begin
                    if (m_elapsed >= m_timeout) end_session();
                    else m_elapsed++;
                end
            end
            CMD_BYTE: begin
                case (m_phase)
                    PH_READY: begin
                        if (it.ovr) begin
                            m_line_cnt = 0;
                            add_text(TX_BAD, 5);
                        end else begin
                            lr = feed_line(it.data);
                            if (lr == LN_DONE && line_is("ready")) begin
                                m_line_cnt = 0;
                                add_text(TX_BFSZ, 6);
                                add_reply(KIND_TX, m_bufsz[15:8], 1'b0);
                                add_reply(KIND_TX, m_bufsz[7:0], 1'b0);
                                m_phase   = PH_INFO;
                                m_elapsed = 16'd0;
                            end else if (lr != LN_WAIT) begin
                                m_line_cnt = 0;
                                add_text(TX_BAD, 5);
                            end
                        end
                    end
                    PH_INFO: begin
                        if (it.ovr) begin
                            end_session();
                        end else begin
                            lr = feed_line(it.data);
                            if (lr == LN_DONE && line_is("info")) begin
                                m_line_cnt = 0;
                                m_phase    = PH_BYTES;
                                m_info     = 64'd0;
                                m_info_cnt = 0;
                                m_elapsed  = 16'd0;
                            end else if (lr != LN_WAIT) begin
                                end_session();
                            end
                        end
                    end
                    PH_BYTES: begin
                        m_info = {m_info[55:0], it.data};
                        m_info_cnt++;
                        if (m_info_cnt >= INFO_BYTES) begin
                            m_info_cnt = 0;
                            m_left     = m_info[15:0];
                            add_text(TX_READY, 7);
                            if (m_left == 16'd0) begin
                                add_reply(KIND_REPORT, 8'd0, 1'b1);
                                end_session();
                            end else begin
                                m_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        add_reply(KIND_PAYLOAD, it.data, 1'b0);
                        if (m_left > 16'd0) m_left--;
                        if (m_left == 16'd0) begin
                            add_reply(KIND_REPORT, 8'd0, 1'b1);
                            end_session();
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (step_replies.size() > 0) step_replies[$].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic reg_write(logic [2:0] addr, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BUFSZ) m_bufsz = val;
        else m_timeout = val;
        @(posedge i_clk);
    endtask

    task automatic send_item(t_stim it, logic typed, logic [3:0] n, logic [63:0] text);
        t_reply r;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data;
        s_axis_tuser  <= {it.ovr, it.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        handshake_step(it);
        if (typed) begin
            for (int i = 0; i < n; i++) begin
                r = '0;
                r.kind       = KIND_TX;
                r.byte_value = text[8*i +: 8];
                r.last       = (i == n - 1);
                expected_replies.push_back(r);
            end
        end else begin
            foreach (step_replies[i]) expected_replies.push_back(step_replies[i]);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        // items without replies may still sit in the input register
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_item(logic [1:0] cmd, logic [7:0] data, logic ovr);
        pending_items.push_back('{cmd, data, ovr});
    endtask

    task automatic add_line(string s);
        for (int i = 0; i < s.len(); i++) add_item(CMD_BYTE, s[i], 1'b0);
        add_item(CMD_BYTE, CHAR_CR, 1'b0);
        add_item(CMD_BYTE, CHAR_LF, 1'b0);
    endtask

    task automatic gen_ready_noise();
        case ($urandom_range(5))
            0: add_item(CMD_BYTE, 8'($urandom), 1'b1);
            1: begin
                repeat ($urandom_range(5)) add_item(CMD_BYTE, 8'($urandom), 1'b0);
                add_item(CMD_BYTE, CHAR_CR, 1'b0);
                add_item(CMD_BYTE, CHAR_LF, 1'b0);
            end
            2: repeat (LINE_MAX) add_item(CMD_BYTE, 8'($urandom), 1'b0);
            3: begin
                if ($urandom_range(1) != 0) add_line("readyy");
                else add_line("read");
            end
            4: begin
                // stray carriage return inside the line
                add_item(CMD_BYTE, "r", 1'b0);
                add_line("eady\015");
            end
            default: begin
                add_item(CMD_TICK, 8'($urandom), 1'($urandom_range(1)));
                add_item(CMD_UNUSED, 8'($urandom), 1'($urandom_range(1)));
            end
        endcase
    endtask

    task automatic gen_session();
        logic [63:0] info;
        logic [15:0] len;
        int          ticks;
        add_item(CMD_START, 8'($urandom), 1'($urandom_range(1)));
        repeat ($urandom_range(2)) gen_ready_noise();
        add_line("ready");
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: add_item(CMD_BYTE, 8'($urandom), 1'b1);
                1: add_line("infoo");
                2: add_line("inf");
                default: repeat (LINE_MAX) add_item(CMD_BYTE, 8'($urandom), 1'b0);
            endcase
            return;
        end
        if (m_timeout <= 16'd8 && $urandom_range(3) == 0) ticks = m_timeout + 1;
        else ticks = $urandom_range(m_timeout < 16'd3 ? m_timeout : 3);
        repeat (ticks) add_item(CMD_TICK, 8'($urandom), 1'($urandom_range(1)));
        add_line("info");
        case ($urandom_range(19))
            0, 1, 2, 3: len = 16'd0;
            4: len = 16'($urandom_range(48, 9));
            default: len = 16'($urandom_range(8, 1));
        endcase
        info = {32'($urandom), 8'($urandom), 8'($urandom), len};
        for (int i = 0; i < INFO_BYTES; i++) begin
            if ($urandom_range(99) < 15)
                add_item(CMD_TICK, 8'($urandom), 1'($urandom_range(1)));
            add_item(CMD_BYTE, info[63-8*i -: 8], 1'($urandom_range(1)));
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 3) return;   // next start cuts the payload short
            if ($urandom_range(99) < 10)
                add_item($urandom_range(1) != 0 ? CMD_TICK : CMD_UNUSED, 8'($urandom),
                         1'($urandom_range(1)));
            add_item(CMD_BYTE, 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    // output side: check every transfer against the oldest expected reply
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected result: kind %0d byte 0x%0h", m_axis_tuser,
                           m_axis_tdata[7:0]);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("byte_value", 32'(want.byte_value), 32'(m_axis_tdata[7:0]));
                    check_field("sample_rate", want.rate, m_axis_tdata[39:8]);
                    check_field("bit_depth", 32'(want.depth), 32'(m_axis_tdata[47:40]));
                    check_field("channels", 32'(want.chans), 32'(m_axis_tdata[55:48]));
                    check_field("data_length", 32'(want.len), 32'(m_axis_tdata[71:56]));
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            m_axis_tready <= !hold_on && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (pressure_start);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [15:0] bs;
        logic [15:0] to;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].n,
                      directed_rows[i].text);
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin bs = 16'd0;     to = 16'd1;     end
                1: begin bs = 16'hffff;  to = 16'hffff;  end
                2: begin bs = 16'($urandom);  to = 16'd3;     end
                3: begin bs = 16'($urandom);  to = 16'd2000;  end
                default: begin
                    bs = 16'($urandom);
                    to = 16'($urandom_range(8, 1));
                end
            endcase
            reg_write(ADDR_BUFSZ, bs);
            reg_write(ADDR_TIMEOUT, to);
            no_idle <= (p == 1);
            if (p == 3) begin
                pressure_start <= 1'b1;
                add_item(CMD_START, 8'd0, 1'b0);
                repeat (40) begin
                    add_item(CMD_BYTE, CHAR_CR, 1'b0);
                    add_item(CMD_BYTE, CHAR_LF, 1'b0);
                end
            end
            while (pending_items.size() < PHASE_ITEMS) gen_session();
            while (pending_items.size() != 0)
                send_item(pending_items.pop_front(), 1'b0, 4'd0, 64'd0);
            drain();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
design/uhe_pkg.sv
design/uhe_core.sv
design/uhe_emit.sv
design/uart_host_handshake_engine.sv
verif/uart_host_handshake_engine_test.sv
